// ===== hdl/tab_pkg.sv =====
// shared types and constants for the timed address blocklist
`timescale 1ns / 1ps

package tab_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned MIN_W  = 16;
  localparam int unsigned OCC_W  = 7;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CHECK  = 2'd2,
    OP_PURGE  = 2'd3
  } op_e;

  // one table slot as held in the memory
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] address;
    logic [TIME_W-1:0] expiry;
  } entry_t;

  // per-slot compare flags from the shared compare unit
  typedef struct packed {
    logic is_free;
    logic is_match;
    logic is_stale;
  } cmp_res_t;

endpackage

// ===== hdl/tab_if.sv =====
// request and response channel interfaces for the timed address blocklist
`timescale 1ns / 1ps

interface tab_req_if import tab_pkg::*; ();
  logic              valid;
  logic              ready;
  op_e               op;
  logic [ADDR_W-1:0] address;
  logic [MIN_W-1:0]  duration_minutes;
  logic [TIME_W-1:0] now_seconds;

  modport source (output valid, op, address, duration_minutes, now_seconds, input ready);
  modport sink   (input valid, op, address, duration_minutes, now_seconds, output ready);
endinterface

interface tab_rsp_if import tab_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic             rejected;
  logic [OCC_W-1:0] occupancy;

  modport source (output valid, hit, rejected, occupancy, input ready);
  modport sink   (input valid, hit, rejected, occupancy, output ready);
endinterface

// ===== hdl/tab_mem.sv =====
// slot memory: one write port, one registered read port
`timescale 1ns / 1ps

module tab_mem import tab_pkg::*; #(
  parameter int unsigned Entries = 64,
  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  entry_t          wdata_i,
  input  logic            re_i,
  input  logic [IdxW-1:0] raddr_i,
  output entry_t          rdata_o
);

  entry_t mem_q [Entries];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/tab_cmp.sv =====
// shared slot compare unit: free, address match and expiry test
`timescale 1ns / 1ps

module tab_cmp import tab_pkg::*; (
  input  entry_t            entry_i,
  input  logic [ADDR_W-1:0] address_i,
  input  logic [TIME_W-1:0] now_i,
  output cmp_res_t          res_o
);

  always_comb begin
    res_o.is_free  = !entry_i.valid;
    res_o.is_match = entry_i.valid && (entry_i.address == address_i);
    // expiry equal to now is kept
    res_o.is_stale = entry_i.valid && (entry_i.expiry < now_i);
  end

endmodule

// ===== hdl/timed_address_blocklist.sv =====
// top level: sequencer that scans the slot memory through one compare unit
// the scan reads slots via the memory register; ST_DONE then loads the response register
// add stops at the first free slot, remove and check at the first matching slot, purge scans all
// a new request is taken only in idle, after ST_DONE; the scan reads one slot a cycle
// reset: a clearing pass writes every slot invalid, ready stays low
// the response register holds a finished result while the next request is taken
`timescale 1ns / 1ps

module timed_address_blocklist import tab_pkg::*; #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tab_req_if.sink    req_i,
  tab_rsp_if.source  rsp_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  // sequencer state
  state_e            state_q, state_d;
  logic [IdxW-1:0]   idx_q, idx_d;         // read issue index, also clear sweep index
  logic              iss_on_q, iss_on_d;   // more reads to issue
  logic              rd_vld_q, rd_vld_d;   // read data in the memory register is live
  logic [IdxW-1:0]   rd_idx_q, rd_idx_d;   // slot that the read data belongs to
  logic [CntW-1:0]   cnt_q, cnt_d;         // number of valid slots

  // request held for the scan
  op_e               op_q;
  logic [ADDR_W-1:0] addr_q;
  logic [TIME_W-1:0] now_q;
  logic [TIME_W-1:0] exp_q;

  // result of the finished scan, then the response register
  logic              hit_q, hit_d;
  logic              rej_q, rej_d;
  logic              rsp_vld_q, rsp_vld_d;
  logic              rsp_hit_q;
  logic              rsp_rej_q;
  logic [OCC_W-1:0]  rsp_occ_q;

  logic              accept;
  logic              rsp_load;
  logic              issue;
  logic              eval;
  logic              stop;
  logic              finish;
  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  entry_t            mem_wdata;
  entry_t            rd_word;
  cmp_res_t          cmp;
  logic [TIME_W-1:0] min_ext;
  logic [TIME_W-1:0] exp_d;

  assign accept   = req_i.valid && req_i.ready;
  assign issue    = (state_q == ST_SCAN) && iss_on_q;
  assign eval     = (state_q == ST_SCAN) && rd_vld_q;
  // a finished result moves out once the response register is free
  assign rsp_load = (state_q == ST_DONE) && (!rsp_vld_q || rsp_o.ready);

  // expiry = now + minutes * 60, as (m << 6) - (m << 2), wrapping mod 2^32
  assign min_ext = TIME_W'(req_i.duration_minutes);
  assign exp_d   = req_i.now_seconds + (min_ext << 6) - (min_ext << 2);

  tab_mem #(
    .Entries (ENTRIES)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (issue),
    .raddr_i (idx_q),
    .rdata_o (rd_word)
  );

  tab_cmp u_cmp (
    .entry_i   (rd_word),
    .address_i (addr_q),
    .now_i     (now_q),
    .res_o     (cmp)
  );

  // per-slot decision for the slot whose read data is live
  always_comb begin
    stop      = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = rd_idx_q;
    mem_wdata = rd_word;
    cnt_d     = cnt_q;
    if (state_q == ST_CLEAR) begin
      // clearing pass after reset
      mem_we          = 1'b1;
      mem_waddr       = idx_q;
      mem_wdata.valid = 1'b0;
    end else if (eval) begin
      case (op_q)
        OP_ADD: begin
          stop              = cmp.is_free;
          mem_we            = cmp.is_free;
          mem_wdata.valid   = 1'b1;
          mem_wdata.address = addr_q;
          mem_wdata.expiry  = exp_q;
          if (cmp.is_free) cnt_d = cnt_q + 1'b1;
        end
        OP_REMOVE: begin
          stop            = cmp.is_match;
          mem_we          = cmp.is_match;
          mem_wdata.valid = 1'b0;
          if (cmp.is_match) cnt_d = cnt_q - 1'b1;
        end
        OP_CHECK: begin
          stop = cmp.is_match;
        end
        default: begin
          // purge visits every slot
          mem_we          = cmp.is_stale;
          mem_wdata.valid = 1'b0;
          if (cmp.is_stale) cnt_d = cnt_q - 1'b1;
        end
      endcase
    end
  end

  assign finish = eval && (stop || (rd_idx_q == LastIdx));

  // sequencer
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    iss_on_d  = iss_on_q;
    rd_vld_d  = rd_vld_q;
    rd_idx_d  = rd_idx_q;
    hit_d     = hit_q;
    rej_d     = rej_q;
    rsp_vld_d = rsp_vld_q;
    if (rsp_vld_q && rsp_o.ready) rsp_vld_d = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == LastIdx) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          idx_d    = '0;
          iss_on_d = 1'b1;
          rd_vld_d = 1'b0;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // read pipeline: issue one slot a cycle, evaluate it the cycle after
        rd_vld_d = issue;
        rd_idx_d = idx_q;
        if (issue) begin
          idx_d = idx_q + 1'b1;
          if (idx_q == LastIdx) iss_on_d = 1'b0;
        end
        if (finish) begin
          iss_on_d = 1'b0;
          rd_vld_d = 1'b0;
          hit_d    = ((op_q == OP_REMOVE) || (op_q == OP_CHECK)) && cmp.is_match;
          rej_d    = (op_q == OP_ADD) && !cmp.is_free;
          state_d  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (rsp_load) begin
          rsp_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      idx_q     <= '0;
      iss_on_q  <= 1'b0;
      rd_vld_q  <= 1'b0;
      rd_idx_q  <= '0;
      cnt_q     <= '0;
      hit_q     <= 1'b0;
      rej_q     <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      iss_on_q  <= iss_on_d;
      rd_vld_q  <= rd_vld_d;
      rd_idx_q  <= rd_idx_d;
      cnt_q     <= cnt_d;
      hit_q     <= hit_d;
      rej_q     <= rej_d;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  // request and response payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= req_i.op;
      addr_q <= req_i.address;
      now_q  <= req_i.now_seconds;
      exp_q  <= exp_d;
    end
    if (rsp_load) begin
      rsp_hit_q <= hit_q;
      rsp_rej_q <= rej_q;
      rsp_occ_q <= OCC_W'(cnt_q);
    end
  end

  assign req_i.ready     = (state_q == ST_IDLE);
  assign rsp_o.valid     = rsp_vld_q;
  assign rsp_o.hit       = rsp_hit_q;
  assign rsp_o.rejected  = rsp_rej_q;
  assign rsp_o.occupancy = rsp_occ_q;

  // occupancy never passes the table size
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(ENTRIES))
    else $error("valid count above table size");

  // an add is dropped only when every slot is in use
  a_rej_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && (op_q == OP_ADD) && !cmp.is_free) |-> (cnt_q == CntW'(ENTRIES)))
    else $error("add rejected with a free slot");

  // no slot write outside the clearing pass and the scan
  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((state_q == ST_CLEAR) || (state_q == ST_SCAN)))
    else $error("slot write while idle or done");

  // live read data only exists during a scan
  a_rd_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == ST_SCAN))
    else $error("read data live outside scan");

  // an accepted request starts a scan from the first slot
  a_acc_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ((state_q == ST_SCAN) && (idx_q == '0) && iss_on_q))
    else $error("accepted request did not start a scan");

endmodule
